FILE: sv/fwog_pkg.sv
// types and constants shared by the flash write order guard
package fwog_pkg;

  localparam int unsigned SLOT_COUNT = 2;

  localparam logic OP_ERASE = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] REG_SLOT_A_SIZE = 2'd0;
  localparam logic [1:0] REG_SLOT_B_SIZE = 2'd1;
  localparam logic [1:0] REG_GRANULE_LOG2 = 2'd2;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_PACKET = 3'd1,
    ST_BAD_ARG    = 3'd2,
    ST_NOT_ERASED = 3'd3,
    ST_SIZE       = 3'd4,
    ST_FLASH_ERR  = 3'd5
  } status_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  slot_number;
    logic [31:0] write_offset;
    logic [15:0] write_length;
    logic        flash_ok;
  } in_t;

  typedef struct packed {
    status_t     status;
    logic        flash_issue;
    logic [31:0] echo_offset;
  } out_t;

endpackage

FILE: sv/flash_write_order_guard.sv
// flash write order guard: checks erase and program ordering in an update session
//
//   channel | direction | handshake            | payload
//   in_     | in        | in_valid / in_stall   | in_t  (op, slot, offset, length, flash_ok)
//   out_    | out       | out_valid / out_stall | out_t (status, flash_issue, echo_offset)
//   cfg_    | in        | apb psel/penable      | slot sizes, write granule log2
//
// one transaction per cycle sustained while out_stall is low; a result passes through the input
// register, then the result register, set by the single check stage
// session state updates as a transaction leaves the input register, so the next
// one is checked against it with no bubble
// reset is synchronous, active low; it clears the session and sets the granule to 4 bytes
// out_stall holds the result register; with both registers full it raises in_stall at once
module flash_write_order_guard
  import fwog_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] slot_a_size_r;
  logic [31:0] slot_b_size_r;
  logic [3:0]  granule_log2_r;

  logic        target_slot_r;
  logic        erased_mark_r;
  logic        header_mark_r;
  logic [31:0] high_water_r;

  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        out_valid_r;
  out_t        out_data_r;

  logic        s1_advance;
  logic        cfg_write;
  logic [31:0] mask;
  logic [31:0] size;
  logic [31:0] len_ext;
  logic [31:0] end_off;
  logic        upd_erase;
  logic        upd_write;
  out_t        res_nxt;

  // handshake
  assign s1_advance = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_SLOT_A_SIZE:  cfg_prdata = slot_a_size_r;
      REG_SLOT_B_SIZE:  cfg_prdata = slot_b_size_r;
      REG_GRANULE_LOG2: cfg_prdata = {28'd0, granule_log2_r};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_a_size_r  <= 32'd0;
      slot_b_size_r  <= 32'd0;
      granule_log2_r <= 4'd2;
    end else if (cfg_write) begin
      unique case (cfg_paddr[3:2])
        REG_SLOT_A_SIZE:  slot_a_size_r <= cfg_pwdata;
        REG_SLOT_B_SIZE:  slot_b_size_r <= cfg_pwdata;
        REG_GRANULE_LOG2: granule_log2_r <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // checks
  assign mask    = (32'd1 << granule_log2_r) - 32'd1;
  assign size    = target_slot_r ? slot_b_size_r : slot_a_size_r;
  assign len_ext = {16'd0, s1_data_r.write_length};
  assign end_off = s1_data_r.write_offset + len_ext;

  always_comb begin
    res_nxt.status      = ST_OK;
    res_nxt.flash_issue = 1'b0;
    res_nxt.echo_offset = 32'd0;
    upd_erase           = 1'b0;
    upd_write           = 1'b0;
    if (s1_data_r.op == OP_ERASE) begin
      priority if ({24'd0, s1_data_r.slot_number} >= 32'(SLOT_COUNT)) begin
        res_nxt.status = ST_BAD_ARG;
      end else if (!s1_data_r.flash_ok) begin
        res_nxt.status      = ST_FLASH_ERR;
        res_nxt.flash_issue = 1'b1;
      end else begin
        res_nxt.flash_issue = 1'b1;
        upd_erase           = 1'b1;
      end
    end else begin
      priority if (s1_data_r.write_length == 16'd0) begin
        res_nxt.status = ST_BAD_PACKET;
      end else if (!erased_mark_r) begin
        res_nxt.status = ST_NOT_ERASED;
      end else if ((s1_data_r.write_offset & mask) != 32'd0 ||
                   (len_ext & mask) != 32'd0) begin
        res_nxt.status = ST_BAD_ARG;
      end else if (s1_data_r.write_offset == 32'd0 && header_mark_r) begin
        res_nxt.status = ST_NOT_ERASED;
      end else if (s1_data_r.write_offset != 32'd0 &&
                   s1_data_r.write_offset < high_water_r) begin
        res_nxt.status = ST_NOT_ERASED;
      end else if (s1_data_r.write_offset > size ||
                   len_ext > size - s1_data_r.write_offset) begin
        res_nxt.status = ST_SIZE;
      end else if (!s1_data_r.flash_ok) begin
        res_nxt.status      = ST_FLASH_ERR;
        res_nxt.flash_issue = 1'b1;
      end else begin
        res_nxt.flash_issue = 1'b1;
        res_nxt.echo_offset = s1_data_r.write_offset;
        upd_write           = 1'b1;
      end
    end
  end

  // session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_slot_r <= 1'b0;
      erased_mark_r <= 1'b0;
      header_mark_r <= 1'b0;
      high_water_r  <= 32'd0;
    end else if (s1_advance) begin
      if (upd_erase) begin
        target_slot_r <= s1_data_r.slot_number[0];
        erased_mark_r <= 1'b1;
        header_mark_r <= 1'b0;
        high_water_r  <= 32'd0;
      end else if (upd_write) begin
        if (s1_data_r.write_offset == 32'd0) begin
          header_mark_r <= 1'b1;
        end
        if (end_off > high_water_r) begin
          high_water_r <= end_off;
        end
      end
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s1_advance) begin
      out_data_r <= res_nxt;
    end
  end

  a_hw_needs_erase: assert property (@(posedge clk) disable iff (!rst_n)
    !erased_mark_r |-> high_water_r == 32'd0 && !header_mark_r)
    else $error("write progress recorded without an erased slot");

  a_erase_arms: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(erased_mark_r) |-> $past(s1_advance && s1_data_r.op == OP_ERASE))
    else $error("session armed by something other than an erase");

  a_issue_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.flash_issue |->
      out_data_r.status == ST_OK || out_data_r.status == ST_FLASH_ERR)
    else $error("flash issued on a rejected transaction");

  a_echo_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.echo_offset != 32'd0 |->
      out_data_r.status == ST_OK && out_data_r.flash_issue)
    else $error("offset echoed on an unsuccessful transaction");

endmodule

FILE: sim/tb_top.sv
// testbench for the flash write order guard: directed and random requests against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fwog_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_t         in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_t        out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int send_idle_pct = 0;
  int stall_pct     = 0;

  // register copies and session state of the guard
  logic [31:0] size_a          = '0;
  logic [31:0] size_b          = '0;
  logic [3:0]  granule_log2    = 4'd2;
  logic        sess_slot       = 1'b0;
  logic        sess_erased     = 1'b0;
  logic        sess_header     = 1'b0;
  logic [31:0] sess_high_water = '0;

  out_t pending_verdicts[$];
  int   mismatch_count   = 0;
  int   verdicts_checked = 0;
  int   requests_sent    = 0;
  int   settings_used    = 0;
  int   idle_cycles      = 0;
  int   status_tally[6];

  // stimulus cursor for well-formed sessions
  logic [31:0] next_offset = '0;
  bit          header_sent = 1'b0;

  flash_write_order_guard u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic out_t guard_verdict(in_t req);
    out_t        v;
    logic [31:0] mask;
    logic [31:0] size;
    logic [31:0] len;
    logic [31:0] fin;
    v.status      = ST_OK;
    v.flash_issue = 1'b0;
    v.echo_offset = '0;
    if (req.op == OP_ERASE) begin
      if (req.slot_number >= SLOT_COUNT) begin
        v.status = ST_BAD_ARG;
      end else if (!req.flash_ok) begin
        v.status      = ST_FLASH_ERR;
        v.flash_issue = 1'b1;
      end else begin
        v.flash_issue   = 1'b1;
        sess_slot       = req.slot_number[0];
        sess_erased     = 1'b1;
        sess_high_water = '0;
        sess_header     = 1'b0;
      end
      return v;
    end
    mask = (32'd1 << granule_log2) - 32'd1;
    size = sess_slot ? size_b : size_a;
    len  = {16'd0, req.write_length};
    if (len == 32'd0) begin
      v.status = ST_BAD_PACKET;
    end else if (!sess_erased) begin
      v.status = ST_NOT_ERASED;
    end else if ((req.write_offset & mask) != 32'd0 || (len & mask) != 32'd0) begin
      v.status = ST_BAD_ARG;
    end else if (req.write_offset == 32'd0 ? sess_header
                                           : (req.write_offset < sess_high_water)) begin
      v.status = ST_NOT_ERASED;
    end else if (req.write_offset > size || len > size - req.write_offset) begin
      v.status = ST_SIZE;
    end else if (!req.flash_ok) begin
      v.status      = ST_FLASH_ERR;
      v.flash_issue = 1'b1;
    end else begin
      v.flash_issue = 1'b1;
      v.echo_offset = req.write_offset;
      if (req.write_offset == 32'd0) sess_header = 1'b1;
      fin = req.write_offset + len;
      if (fin > sess_high_water) sess_high_water = fin;
    end
    return v;
  endfunction

  // result check first, then the newly accepted transaction is predicted
  always @(posedge clk) begin : monitor
    out_t want;
    bit   active;
    if (rst_n) begin
      active = 1'b0;
      if (out_valid && !out_stall) begin
        active = 1'b1;
        if (pending_verdicts.size() == 0) begin
          mismatch_count++;
          $display("%0t: expected no result, actual status %0d issue %0b echo %08h",
                   $time, out_data.status, out_data.flash_issue, out_data.echo_offset);
        end else begin
          want = pending_verdicts.pop_front();
          verdicts_checked++;
          status_tally[want.status]++;
          if (out_data.status !== want.status || out_data.flash_issue !== want.flash_issue ||
              out_data.echo_offset !== want.echo_offset) begin
            mismatch_count++;
            $display("%0t: status/issue/echo expected %0d/%0b/%08h actual %0d/%0b/%08h",
                     $time, want.status, want.flash_issue, want.echo_offset,
                     out_data.status, out_data.flash_issue, out_data.echo_offset);
          end
        end
      end
      if (in_valid && !in_stall) begin
        active = 1'b1;
        pending_verdicts.push_back(guard_verdict(in_data));
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_request(in_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SLOT_A_SIZE:  size_a = value;
      REG_SLOT_B_SIZE:  size_b = value;
      REG_GRANULE_LOG2: granule_log2 = value[3:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_setting(logic [31:0] a, logic [31:0] b, logic [3:0] g);
    wait_idle();
    write_reg(REG_SLOT_A_SIZE, a);
    write_reg(REG_SLOT_B_SIZE, b);
    write_reg(REG_GRANULE_LOG2, {28'd0, g});
    settings_used++;
    next_offset = '0;
    header_sent = 1'b0;
  endtask

  function automatic in_t erase_req(logic [7:0] slot, bit ok);
    in_t r;
    r.op           = OP_ERASE;
    r.slot_number  = slot;
    r.write_offset = $urandom;
    r.write_length = 16'($urandom);
    r.flash_ok     = ok;
    return r;
  endfunction

  function automatic in_t write_req(logic [31:0] off, logic [15:0] len, bit ok);
    in_t r;
    r.op           = OP_WRITE;
    r.slot_number  = 8'($urandom);
    r.write_offset = off;
    r.write_length = len;
    r.flash_ok     = ok;
    return r;
  endfunction

  // mostly ascending sessions, with broken orderings and raw noise mixed in
  function automatic in_t session_request();
    int          pick;
    int          kmax;
    logic [31:0] unit;
    logic [31:0] off;
    logic [31:0] len;
    in_t         r;
    pick = $urandom_range(99);
    unit = 32'd1 << granule_log2;
    kmax = 65535 >> granule_log2;
    if (kmax > 8) kmax = 8;
    if (pick < 8) begin
      next_offset = unit;
      header_sent = 1'b0;
      return erase_req(8'($urandom_range(1)), $urandom_range(9) != 0);
    end else if (pick < 11) begin
      return erase_req(8'($urandom_range(255)), 1'($urandom_range(1)));
    end else if (pick < 78) begin
      len = unit * $urandom_range(1, kmax);
      if (!header_sent && $urandom_range(9) == 0) begin
        off         = '0;
        header_sent = 1'b1;
      end else begin
        off = next_offset;
        if ($urandom_range(19) == 0) off += unit * $urandom_range(1, 1000);
        next_offset = off + len;
      end
      return write_req(off, len[15:0], $urandom_range(19) != 0);
    end else if (pick < 88) begin
      if ($urandom_range(1) == 1) off = next_offset - unit * $urandom_range(0, 4);
      else off = next_offset + $urandom_range(1, 3);
      len = $urandom_range(1, 2 * unit);
      return write_req(off, len[15:0], 1'($urandom_range(1)));
    end
    r.write_offset = $urandom_range(32'h7FFF);
    r.op           = 1'($urandom_range(1));
    r.slot_number  = 8'($urandom);
    r.flash_ok     = 1'($urandom_range(1));
    r.write_length = 16'($urandom);
    return r;
  endfunction

  task automatic random_setting(int k);
    logic [3:0]  granule_choice [8] = '{4'd2, 4'd0, 4'd5, 4'd15, 4'd3, 4'd9, 4'd1, 4'd8};
    logic [3:0]  g;
    logic [31:0] unit;
    logic [31:0] a;
    logic [31:0] b;
    g    = granule_choice[k];
    unit = 32'd1 << g;
    a    = unit * $urandom_range(4, 64);
    b    = unit * $urandom_range(4, 64);
    if (k == 1) begin
      a = '0;
      b = 32'hFFFF_FFFF;
    end else if (k == 3) begin
      a = 32'hFFFF_FFFF;
    end else if (k == 6) begin
      b = '0;
    end
    apply_setting(a, b, g);
  endtask

  task automatic test_before_erase();
    send_request(write_req(32'd0, 16'd0, 1'b1));
    send_request(write_req(32'd16, 16'd16, 1'b1));
    send_request(erase_req(8'd2, 1'b1));
    send_request(erase_req(8'd255, 1'b1));
    send_request(erase_req(8'd0, 1'b0));
  endtask

  task automatic test_write_order();
    apply_setting(32'd256, 32'd1024, 4'd2);
    send_request(erase_req(8'd1, 1'b1));
    send_request(write_req(32'd0, 16'd16, 1'b1));
    send_request(write_req(32'd16, 16'd32, 1'b1));
    send_request(write_req(32'd32, 16'd8, 1'b1));
    send_request(write_req(32'd0, 16'd4, 1'b1));
    send_request(write_req(32'd50, 16'd4, 1'b1));
    send_request(write_req(32'd48, 16'd6, 1'b1));
    send_request(write_req(32'd2048, 16'd4, 1'b1));
    send_request(write_req(32'd1020, 16'd8, 1'b1));
    send_request(write_req(32'd1008, 16'd16, 1'b0));
    send_request(write_req(32'd1008, 16'd16, 1'b1));
    send_request(erase_req(8'd0, 1'b1));
    send_request(write_req(32'd64, 16'd4, 1'b1));
    send_request(write_req(32'd256, 16'd4, 1'b1));
  endtask

  task automatic test_size_extremes();
    apply_setting(32'hFFFF_FFFF, 32'd0, 4'd0);
    send_request(erase_req(8'd0, 1'b1));
    send_request(write_req(32'hFFFF_0000, 16'hFFFF, 1'b1));
    send_request(write_req(32'hFFFF_FFFF, 16'd1, 1'b1));
    send_request(erase_req(8'd1, 1'b1));
    send_request(write_req(32'd0, 16'd1, 1'b1));
    apply_setting(32'd0, 32'hFFFF_FFFF, 4'd15);
    send_request(erase_req(8'd1, 1'b1));
    send_request(write_req(32'h0000_8000, 16'h8000, 1'b1));
    send_request(write_req(32'h0001_0000, 16'h4000, 1'b1));
  endtask

  task automatic test_random_traffic();
    int idle_plan  [4] = '{0, 73, 0, 17};
    int stall_plan [4] = '{0, 0, 73, 17};
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = idle_plan[phase];
      stall_pct     = stall_plan[phase];
      for (int s = 0; s < 2; s++) begin
        random_setting(phase * 2 + s);
        repeat (175) send_request(session_request());
      end
    end
  endtask

  initial begin : run
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_before_erase();
    test_write_order();
    test_size_extremes();
    test_random_traffic();
    wait_idle();
    $display("%0d requests, %0d register settings, four handshake phases, %0d results checked",
             requests_sent, settings_used, verdicts_checked);
    $display("status mix: ok %0d, packet %0d, arg %0d, not erased %0d, size %0d, flash %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4], status_tally[5]);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
